[rtl/mwra_pkg.sv]
package mwra_pkg;

  // Store and field sizes
  localparam int MASK_ENTRIES = 1024;
  localparam int MASK_IDX_W   = $clog2(MASK_ENTRIES);
  localparam int ENTRY_W      = 10;
  localparam int WEIGHT_W     = 16;
  localparam int PIX_W        = 8;
  localparam int PROD_W       = WEIGHT_W + PIX_W;

  // Accumulator widths; sums wrap at these widths
  localparam int CH_ACC_W     = 34;
  localparam int WT_ACC_W     = 26;

  // Averages are clamped to 0..255, so eight quotient bits plus a saturation test
  localparam int QUOT_BITS    = PIX_W;
  localparam int QIDX_W       = $clog2(QUOT_BITS);
  localparam int STEP_W       = $clog2(QUOT_BITS + 1);
  localparam int NUM_CH       = 3;

  // Window-sum queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // One closed window: three channel sums and the weight sum
  typedef struct packed {
    logic [CH_ACC_W-1:0] red_sum;
    logic [CH_ACC_W-1:0] green_sum;
    logic [CH_ACC_W-1:0] blue_sum;
    logic [WT_ACC_W-1:0] weight_sum;
  } sums_t;

  // Queue write side toward the front
  typedef struct packed {
    logic  push;
    sums_t data;
  } qwr_t;

  // Queue read side toward the back
  typedef struct packed {
    logic  valid;
    sums_t data;
  } qrd_t;

endpackage

[rtl/mwra_front.sv]
module mwra_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [0:0]                    in_op,
  input  logic [mwra_pkg::ENTRY_W-1:0]  in_entry,
  input  logic [mwra_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [mwra_pkg::PIX_W-1:0]    in_red,
  input  logic [mwra_pkg::PIX_W-1:0]    in_green,
  input  logic [mwra_pkg::PIX_W-1:0]    in_blue,
  input  logic                          in_inside_req,
  input  logic                          in_last,
  output mwra_pkg::qwr_t                q_wr,
  input  logic                          q_full
);
  import mwra_pkg::*;

  logic [WEIGHT_W-1:0]   mask_mem [MASK_ENTRIES];
  logic [MASK_IDX_W-1:0] idx;
  logic                  in_range;
  logic                  accept;
  logic                  advance;
  logic                  is_pixel;

  // Stage 1: weight read from the store
  logic                  s1_valid_r;
  logic                  s1_use_r;
  logic                  s1_last_r;
  logic [WEIGHT_W-1:0]   s1_weight_r;
  logic [PIX_W-1:0]      s1_red_r;
  logic [PIX_W-1:0]      s1_green_r;
  logic [PIX_W-1:0]      s1_blue_r;
  logic [WEIGHT_W-1:0]   s1_w;

  // Stage 2: products
  logic                  s2_valid_r;
  logic                  s2_last_r;
  logic [PROD_W-1:0]     s2_red_r;
  logic [PROD_W-1:0]     s2_green_r;
  logic [PROD_W-1:0]     s2_blue_r;
  logic [WEIGHT_W-1:0]   s2_w_r;

  // Accumulators
  logic [CH_ACC_W-1:0]   red_acc_r;
  logic [CH_ACC_W-1:0]   green_acc_r;
  logic [CH_ACC_W-1:0]   blue_acc_r;
  logic [WT_ACC_W-1:0]   weight_acc_r;
  sums_t                 sums_nxt;

  // Hold the whole pipe only when a closing pixel meets a full queue
  assign advance  = !(s2_valid_r && s2_last_r && q_full);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign is_pixel = (in_op == OP_PIXEL);
  assign in_range = (32'(in_entry) < MASK_ENTRIES);
  assign idx      = MASK_IDX_W'(in_entry);

  // Write the mask store on a load word
  always_ff @(posedge clk) begin
    if (accept && !is_pixel && in_range) begin
      mask_mem[idx] <= in_weight;
    end
  end

  // Read the mask store; hold the read data while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_weight_r <= mask_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept && is_pixel;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_use_r   <= in_range && in_inside_req;
      s1_last_r  <= in_last;
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
    end
  end

  // Drop the weight of outside or out-of-range pixels
  assign s1_w = s1_use_r ? s1_weight_r : '0;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_last_r  <= s1_last_r;
      s2_w_r     <= s1_w;
      s2_red_r   <= s1_w * s1_red_r;
      s2_green_r <= s1_w * s1_green_r;
      s2_blue_r  <= s1_w * s1_blue_r;
    end
  end

  // Running sums including the pixel in stage 2
  always_comb begin
    sums_nxt.red_sum    = red_acc_r + CH_ACC_W'(s2_red_r);
    sums_nxt.green_sum  = green_acc_r + CH_ACC_W'(s2_green_r);
    sums_nxt.blue_sum   = blue_acc_r + CH_ACC_W'(s2_blue_r);
    sums_nxt.weight_sum = weight_acc_r + WT_ACC_W'(s2_w_r);
  end

  // Accumulate; on the closing pixel push the sums and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_acc_r    <= '0;
      green_acc_r  <= '0;
      blue_acc_r   <= '0;
      weight_acc_r <= '0;
    end else if (advance && s2_valid_r) begin
      if (s2_last_r) begin
        red_acc_r    <= '0;
        green_acc_r  <= '0;
        blue_acc_r   <= '0;
        weight_acc_r <= '0;
      end else begin
        red_acc_r    <= sums_nxt.red_sum;
        green_acc_r  <= sums_nxt.green_sum;
        blue_acc_r   <= sums_nxt.blue_sum;
        weight_acc_r <= sums_nxt.weight_sum;
      end
    end
  end

  assign q_wr.push = advance && s2_valid_r && s2_last_r;
  assign q_wr.data = sums_nxt;

endmodule

[rtl/mwra_queue.sv]
module mwra_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  mwra_pkg::qwr_t q_wr,
  output logic           q_full,
  input  logic           q_pop,
  output mwra_pkg::qrd_t q_rd
);
  import mwra_pkg::*;

  sums_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign q_full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.data  = slot_r[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wr.data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("window sums pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("pop from an empty queue");
`endif

endmodule

[rtl/mwra_back.sv]
module mwra_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mwra_pkg::qrd_t             q_rd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mwra_pkg::PIX_W-1:0] out_red_avg,
  output logic [mwra_pkg::PIX_W-1:0] out_green_avg,
  output logic [mwra_pkg::PIX_W-1:0] out_blue_avg,
  output logic                       out_empty_res
);
  import mwra_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [STEP_W-1:0]   k_r;
  logic [WT_ACC_W-1:0] w_r;
  logic [CH_ACC_W-1:0] rem_r [NUM_CH];
  logic [PIX_W-1:0]    q_r   [NUM_CH];
  logic [NUM_CH-1:0]   sat_r;
  logic                empty_r;
  logic [CH_ACC_W-1:0] dvs;
  logic [NUM_CH-1:0]   ge;
  logic [PIX_W-1:0]    avg   [NUM_CH];
  logic                out_valid_r;
  logic                out_free;
  logic                load_out;

  // Divisor aligned to the current quotient bit; the top step tests for saturation
  assign dvs = CH_ACC_W'(w_r) << k_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ge[c]  = (rem_r[c] >= dvs);
      avg[c] = sat_r[c] ? '1 : q_r[c];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_DONE) && out_free;
  assign q_pop    = (state_r == ST_IDLE) && q_rd.valid;

  // Sequence: take a window, divide bit by bit unless the weight sum is zero, hand off
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_rd.valid) begin
          state_nxt = (q_rd.data.weight_sum == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (k_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Restoring division, three channels side by side
  always_ff @(posedge clk) begin
    if (q_pop) begin
      k_r      <= STEP_W'(QUOT_BITS);
      w_r      <= q_rd.data.weight_sum;
      rem_r[0] <= q_rd.data.red_sum;
      rem_r[1] <= q_rd.data.green_sum;
      rem_r[2] <= q_rd.data.blue_sum;
      empty_r  <= (q_rd.data.weight_sum == '0);
      sat_r    <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        q_r[c] <= '0;
      end
    end else if (state_r == ST_DIV) begin
      k_r <= k_r - 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        if (ge[c]) begin
          rem_r[c] <= rem_r[c] - dvs;
          if (k_r == STEP_W'(QUOT_BITS)) begin
            sat_r[c] <= 1'b1;
          end else begin
            q_r[c][k_r[QIDX_W-1:0]] <= 1'b1;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red_avg   <= avg[0];
      out_green_avg <= avg[1];
      out_blue_avg  <= avg[2];
      out_empty_res <= empty_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && k_r == '0) |=> (state_r == ST_DONE))
    else $error("division did not finish after the last quotient bit");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_DIV || state_r == ST_DONE))
    else $error("window taken without starting its division");
`endif

endmodule

[rtl/masked_weighted_rgb_average.sv]
// Masked weighted RGB average. Load words (op 0) write one unsigned weight into a
// 1024-entry mask store; pixel words (op 1) look up the weight of their entry and,
// when inside_req is set, add weight*colour and the weight into wrapping sums. The
// pixel with last set closes the window: each channel sum is divided by the weight
// sum, truncated and clamped to 255, or zeros with empty_res when the weight sum is
// zero. The front end takes one word per cycle, loads and pixels alike, unless a
// closing pixel meets a full queue. Closed windows enter a four-deep queue after
// the weight-read and product stages. The back end divides one window at a time,
// a saturation step, then eight quotient bits, one restoring-division step per
// cycle. Long windows stream; short ones fill the queue and then stall the input.
module masked_weighted_rgb_average (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [0:0]                    in_op,
  input  logic [mwra_pkg::ENTRY_W-1:0]  in_entry,
  input  logic [mwra_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [mwra_pkg::PIX_W-1:0]    in_red,
  input  logic [mwra_pkg::PIX_W-1:0]    in_green,
  input  logic [mwra_pkg::PIX_W-1:0]    in_blue,
  input  logic                          in_inside_req,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mwra_pkg::PIX_W-1:0]    out_red_avg,
  output logic [mwra_pkg::PIX_W-1:0]    out_green_avg,
  output logic [mwra_pkg::PIX_W-1:0]    out_blue_avg,
  output logic                          out_empty_res
);
  import mwra_pkg::*;

  qwr_t q_wr;
  qrd_t q_rd;
  logic q_full;
  logic q_pop;

  // Accept and accumulate
  mwra_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_entry      (in_entry),
    .in_weight     (in_weight),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_inside_req (in_inside_req),
    .in_last       (in_last),
    .q_wr          (q_wr),
    .q_full        (q_full)
  );

  // Buffer closed windows
  mwra_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  // Divide and deliver
  mwra_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd          (q_rd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_avg   (out_red_avg),
    .out_green_avg (out_green_avg),
    .out_blue_avg  (out_blue_avg),
    .out_empty_res (out_empty_res)
  );

endmodule
